// File: hw/rtl/tsa_pkg.sv
// Shared types, constants and codes for the twin-stack shared store.
`default_nettype none

package tsa_pkg;

   localparam int DEPTH    = 16;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int OQ_DEPTH = 2;
   localparam int OQ_LW    = $clog2(OQ_DEPTH + 1);

   typedef logic [OPCODE_W-1:0]      opcode_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [AW-1:0]            addr_type;
   typedef logic [CW-1:0]            cnt_type;

   localparam opcode_type OP_PUSH_ONE = 3'd0;
   localparam opcode_type OP_PUSH_TWO = 3'd1;
   localparam opcode_type OP_POP_ONE  = 3'd2;
   localparam opcode_type OP_POP_TWO  = 3'd3;
   localparam opcode_type OP_DUMP_ONE = 3'd4;
   localparam opcode_type OP_DUMP_TWO = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   typedef struct packed {
      status_type status;
      data_type   data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic     en;
      logic     we;
      addr_type addr;
      data_type wdata;
   } ram_req_type;

   typedef struct packed {
      logic [OQ_LW-1:0] level;
      logic             pop;
   } oq_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/tsa_if.sv
// Request and response channel interfaces for the twin-stack shared store.
`default_nettype none

interface tsa_req_if;
   logic                 valid;
   logic                 ready;
   tsa_pkg::opcode_type  opcode;
   tsa_pkg::data_type    value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface tsa_rsp_if;
   logic                 valid;
   logic                 ready;
   tsa_pkg::status_type  status;
   tsa_pkg::data_type    data;
   logic                 last;

   modport source (output valid, output status, output data, output last, input ready);
   modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/twin_stack_shared_array.sv
// Top level: two stacks growing toward each other in one shared store.
// A result word passes the access stage, then the response queue, before rsp offers it.
// Throughput: one push or pop per cycle while the queue has room; a dump holds off req,
// reading one store entry per cycle on the single RAM port while the queue has room.
// A two-word response queue lets requests keep flowing while a word waits on rsp.
// Reset clears both stack pointers, the sequencer and the queue; the store is not cleared.
`default_nettype none

module twin_stack_shared_array (
   input  wire logic   clock,
   input  wire logic   reset,
   tsa_req_if.sink     req,
   tsa_rsp_if.source   rsp
);

   tsa_pkg::ram_req_type  ram_req;
   tsa_pkg::data_type     ram_rdata;
   tsa_pkg::oq_stat_type  oq_stat;
   tsa_pkg::rsp_type      rsp_word;
   logic                  rsp_push;

   // Decode requests, move the pointers and sequence dumps. Every word passes
   // through one access stage so that read data from the store lines up.
   tsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_value  (req.value),
      .req_ready  (req.ready),
      .oq_stat    (oq_stat),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_push   (rsp_push),
      .rsp_word   (rsp_word)
   );

   // Shared store: stack one from entry 0 up, stack two from the top down.
   // Only one operation touches it per cycle, and a write always lands before
   // any later read, so no forwarding is needed.
   tsa_ram #(
      .WIDTH (tsa_pkg::DATA_W),
      .DEPTH (tsa_pkg::DEPTH),
      .AW    (tsa_pkg::AW)
   ) u_ram (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   // Hold finished words until the consumer takes them.
   tsa_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .word  (rsp_word),
      .stat  (oq_stat),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// File: hw/rtl/tsa_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module tsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tsa_outq.sv
// Two-word response queue that decouples the sequencer from the response channel.
`default_nettype none

module tsa_outq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tsa_pkg::rsp_type     word,
   output tsa_pkg::oq_stat_type      stat,
   tsa_rsp_if.source                 rsp
);

   tsa_pkg::rsp_type            mem_ff [tsa_pkg::OQ_DEPTH];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [tsa_pkg::OQ_LW-1:0]   level_ff, level_in;
   logic                        pop;

   assign rsp.valid  = (level_ff != '0);
   assign pop        = rsp.valid && rsp.ready;
   assign rsp.status = mem_ff[rd_ptr_ff].status;
   assign rsp.data   = mem_ff[rd_ptr_ff].data;
   assign rsp.last   = mem_ff[rd_ptr_ff].last;

   assign stat.level = level_ff;
   assign stat.pop   = pop;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + tsa_pkg::OQ_LW'(push) - tsa_pkg::OQ_LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= tsa_pkg::OQ_LW'(tsa_pkg::OQ_DEPTH))
      else $error("response queue level out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && level_ff == tsa_pkg::OQ_LW'(tsa_pkg::OQ_DEPTH)))
      else $error("response queue overflow");

endmodule

`default_nettype wire

// File: hw/rtl/tsa_ctrl.sv
// Stack pointers, opcode decode, dump sequencer and store access stage.
`default_nettype none

module tsa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire tsa_pkg::opcode_type   req_opcode,
   input  wire tsa_pkg::data_type     req_value,
   output logic                       req_ready,
   input  wire tsa_pkg::oq_stat_type  oq_stat,
   output tsa_pkg::ram_req_type       ram_req,
   input  wire tsa_pkg::data_type     ram_rdata,
   output logic                       rsp_push,
   output tsa_pkg::rsp_type           rsp_word
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   localparam tsa_pkg::cnt_type  TOP  = tsa_pkg::CW'(tsa_pkg::DEPTH);
   localparam tsa_pkg::addr_type LAST = tsa_pkg::AW'(tsa_pkg::DEPTH - 1);

   logic                 state_ff, state_in;
   tsa_pkg::cnt_type     count_ff, count_in;
   tsa_pkg::cnt_type     base_ff, base_in;
   tsa_pkg::addr_type    idx_ff, idx_in;
   logic                 up_ff, up_in;

   logic                 s1_valid_ff, s1_valid_in;
   tsa_pkg::status_type  s1_status_ff, s1_status_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_rd_ff, s1_rd_in;

   logic                 room;
   logic                 accept;
   logic                 full;
   logic                 empty_one;
   logic                 empty_two;
   logic                 dump_end;
   tsa_pkg::cnt_type     count_m1;
   tsa_pkg::cnt_type     base_m1;

   assign full      = (count_ff == base_ff);
   assign empty_one = (count_ff == '0);
   assign empty_two = (base_ff == TOP);
   assign count_m1  = count_ff - 1'b1;
   assign base_m1   = base_ff - 1'b1;
   assign dump_end  = up_ff ? (idx_ff == LAST) : (idx_ff == '0);

   // room in the queue for one more word, counting the one in the access stage
   assign room = ({1'b0, oq_stat.level} + tsa_pkg::OQ_LW'(s1_valid_ff) + 1'b0)
                 < (tsa_pkg::OQ_LW'(tsa_pkg::OQ_DEPTH) + tsa_pkg::OQ_LW'(oq_stat.pop));

   assign req_ready = (state_ff == S_IDLE) && room;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      up_in         = up_ff;
      ram_req.en    = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.addr  = '0;
      ram_req.wdata = req_value;
      s1_valid_in   = 1'b0;
      s1_status_in  = tsa_pkg::ST_OK;
      s1_last_in    = 1'b1;
      s1_rd_in      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  tsa_pkg::OP_PUSH_ONE: begin
                     s1_valid_in = 1'b1;
                     if (full) begin
                        s1_status_in = tsa_pkg::ST_FULL;
                     end else begin
                        ram_req.en   = 1'b1;
                        ram_req.we   = 1'b1;
                        ram_req.addr = count_ff[tsa_pkg::AW-1:0];
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  tsa_pkg::OP_PUSH_TWO: begin
                     s1_valid_in = 1'b1;
                     if (full) begin
                        s1_status_in = tsa_pkg::ST_FULL;
                     end else begin
                        ram_req.en   = 1'b1;
                        ram_req.we   = 1'b1;
                        ram_req.addr = base_m1[tsa_pkg::AW-1:0];
                        base_in      = base_m1;
                     end
                  end
                  tsa_pkg::OP_POP_ONE: begin
                     s1_valid_in = 1'b1;
                     if (empty_one) begin
                        s1_status_in = tsa_pkg::ST_EMPTY;
                     end else begin
                        ram_req.en   = 1'b1;
                        ram_req.addr = count_m1[tsa_pkg::AW-1:0];
                        s1_rd_in     = 1'b1;
                        count_in     = count_m1;
                     end
                  end
                  tsa_pkg::OP_POP_TWO: begin
                     s1_valid_in = 1'b1;
                     if (empty_two) begin
                        s1_status_in = tsa_pkg::ST_EMPTY;
                     end else begin
                        ram_req.en   = 1'b1;
                        ram_req.addr = base_ff[tsa_pkg::AW-1:0];
                        s1_rd_in     = 1'b1;
                        base_in      = base_ff + 1'b1;
                     end
                  end
                  tsa_pkg::OP_DUMP_ONE: begin
                     if (empty_one) begin
                        s1_valid_in  = 1'b1;
                        s1_status_in = tsa_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = count_m1[tsa_pkg::AW-1:0];
                        up_in    = 1'b0;
                     end
                  end
                  tsa_pkg::OP_DUMP_TWO: begin
                     if (empty_two) begin
                        s1_valid_in  = 1'b1;
                        s1_status_in = tsa_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = base_ff[tsa_pkg::AW-1:0];
                        up_in    = 1'b1;
                     end
                  end
                  default: begin
                     // unused opcodes: drop silently
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (room) begin
               ram_req.en   = 1'b1;
               ram_req.addr = idx_ff;
               s1_valid_in  = 1'b1;
               s1_rd_in     = 1'b1;
               s1_last_in   = dump_end;
               if (dump_end) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = up_ff ? idx_ff + 1'b1 : idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         base_ff     <= TOP;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         base_ff     <= base_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      up_ff        <= up_in;
      s1_status_ff <= s1_status_in;
      s1_last_ff   <= s1_last_in;
      s1_rd_ff     <= s1_rd_in;
   end

   assign rsp_push        = s1_valid_ff;
   assign rsp_word.status = s1_status_ff;
   assign rsp_word.data   = s1_rd_ff ? ram_rdata : '0;
   assign rsp_word.last   = s1_last_ff;

   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      count_ff <= base_ff && base_ff <= TOP)
      else $error("stack pointers crossed");

   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |->
         (up_ff && tsa_pkg::CW'(idx_ff) >= base_ff) ||
         (!up_ff && tsa_pkg::CW'(idx_ff) < count_ff))
      else $error("dump index outside its stack");

   a_dump_holds_ptrs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> $stable(count_ff) && $stable(base_ff))
      else $error("pointers moved during dump");

endmodule

`default_nettype wire
